FILE: sv/ramped_gain_mixer_dc_block_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the ramped gain mixer
// Short forms for the concurrent checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef RAMPED_GAIN_MIXER_DC_BLOCK_MACROS_SVH
`define RAMPED_GAIN_MIXER_DC_BLOCK_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RGM_ASSERT_NOW(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RGM_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/rgm_pkg.sv
// ----------------------------------------------------------------------------
// rgm_pkg
// Types, constants and helper functions of the ramped gain mixer.
// ----------------------------------------------------------------------------
package rgm_pkg;

  localparam int RGM_NUM_SLOTS = 8;

  localparam int SLOT_W   = 3;
  localparam int LEVEL_W  = 16;
  localparam int SAMPLE_W = 24;
  localparam int GAIN_W   = 16;
  localparam int PROD_W   = SAMPLE_W + GAIN_W + 1;
  localparam int SUM_W    = 32;

  // Register map of the configuration port.
  localparam int CFG_IDX_W = 2;
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RAMP_STEP = 2'd0,
    REG_POLE_COEF = 2'd1
  } rgm_reg_t;

  localparam logic [15:0] RAMP_STEP_RST = 16'd68;
  localparam logic [15:0] POLE_COEF_RST = 16'd65364;
  localparam logic [15:0] POLE_MAX      = 16'd65529;

  localparam logic signed [SUM_W-1:0] OUT_LIMIT = 32'sd5242880;

  typedef struct packed {
    logic [SLOT_W-1:0]          slot_index;
    logic                       slot_active;
    logic                       slot_muted;
    logic [LEVEL_W-1:0]         target_level;
    logic signed [SAMPLE_W-1:0] tap_sample;
    logic                       frame_end;
  } rgm_word_t;

  // Saturate a 34-bit signed value to the signed 32-bit range.
  function automatic logic signed [SUM_W-1:0] sat32(input logic signed [SUM_W+1:0] v);
    logic signed [SUM_W+1:0] hi;
    logic signed [SUM_W+1:0] lo;
    hi = 34'sh0_7FFF_FFFF;
    lo = -34'sh0_8000_0000;
    if (v > hi) begin
      sat32 = 32'sh7FFF_FFFF;
    end else if (v < lo) begin
      sat32 = 32'sh8000_0000;
    end else begin
      sat32 = v[SUM_W-1:0];
    end
  endfunction

  // Clamp the blocker output to plus or minus 10 V in Q4.19.
  function automatic logic signed [SAMPLE_W-1:0] clamp_out(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] c;
    c = v;
    if (v > OUT_LIMIT) begin
      c = OUT_LIMIT;
    end else if (v < -OUT_LIMIT) begin
      c = -OUT_LIMIT;
    end
    clamp_out = c[SAMPLE_W-1:0];
  endfunction

endpackage

FILE: sv/rgm_gain_ramp.sv
// ----------------------------------------------------------------------------
// rgm_gain_ramp
// Per-channel gain store, gain ramp toward the target and sample scaling.
// ----------------------------------------------------------------------------
module rgm_gain_ramp #(
  parameter int NUM_SLOTS = rgm_pkg::RGM_NUM_SLOTS
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                upd_en,
  input  rgm_pkg::rgm_word_t                  word,
  input  logic [15:0]                         ramp_step,
  output logic signed [rgm_pkg::PROD_W-1:0]   prod,
  output logic                                hit
);
  import rgm_pkg::*;

  // Only the slots that the index field can reach are stored.
  localparam int GAIN_DEPTH = (NUM_SLOTS < (1 << SLOT_W)) ? NUM_SLOTS : (1 << SLOT_W);
  localparam int IDX_W      = (GAIN_DEPTH > 1) ? $clog2(GAIN_DEPTH) : 1;

  logic [GAIN_W-1:0] gain_r [GAIN_DEPTH];

  logic              in_range;
  logic [IDX_W-1:0]  gidx;
  logic [GAIN_W-1:0] g_cur;
  logic [GAIN_W-1:0] target;
  logic [GAIN_W:0]   up;
  logic [GAIN_W-1:0] gap;
  logic [GAIN_W-1:0] g_nxt;

  always_comb begin
    in_range = (32'(word.slot_index) < 32'(GAIN_DEPTH));
    gidx     = IDX_W'(word.slot_index);
    g_cur    = in_range ? gain_r[gidx] : '0;
    target   = word.slot_muted ? '0 : word.target_level;
    up       = {1'b0, g_cur} + {1'b0, ramp_step};
    gap      = g_cur - target;
    g_nxt    = g_cur;
    if (g_cur < target) begin
      g_nxt = (up < {1'b0, target}) ? up[GAIN_W-1:0] : target;
    end else if (g_cur > target) begin
      g_nxt = (gap > ramp_step) ? (g_cur - ramp_step) : target;
    end
    hit  = in_range && word.slot_active;
    prod = word.tap_sample * $signed({1'b0, g_nxt});
  end

  // An inactive channel drops its gain, so it restarts from silence.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < GAIN_DEPTH; i++) begin
        gain_r[i] <= '0;
      end
    end else if (upd_en && in_range) begin
      gain_r[gidx] <= word.slot_active ? g_nxt : '0;
    end
  end

endmodule

FILE: sv/ramped_gain_mixer_dc_block.sv
// ----------------------------------------------------------------------------
// ramped_gain_mixer_dc_block
// Monitor mixer: ramped channel gains, frame sum, one-pole DC blocker.
// ----------------------------------------------------------------------------
// The block takes one channel word per clock cycle and keeps taking one per
// cycle for as long as the result side does not stall. A word passes an input
// register, a stage that ramps the channel gain and scales the sample, and a
// stage that adds it to the frame sum; a word with frame_end set then goes
// through the DC blocker stage into the output register. The blocker stage, a
// 16 by 32 bit multiply of the pole with the previous blocker output followed
// by an add and saturation, closes a feedback loop through the blocker output
// register and sets the clock limit. While the output is stalled, words
// without frame_end still drain into the frame sum; in_stall rises once two
// frame_end words wait behind the output register and one more word sits in
// the input register. There is no clearing pass after reset.
// ----------------------------------------------------------------------------
module ramped_gain_mixer_dc_block #(
  parameter int NUM_SLOTS = rgm_pkg::RGM_NUM_SLOTS
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  // input words
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic [rgm_pkg::SLOT_W-1:0]             in_slot_index,
  input  logic                                   in_slot_active,
  input  logic                                   in_slot_muted,
  input  logic [rgm_pkg::LEVEL_W-1:0]            in_target_level,
  input  logic signed [rgm_pkg::SAMPLE_W-1:0]    in_tap_sample,
  input  logic                                   in_frame_end,
  // result words
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [rgm_pkg::SAMPLE_W-1:0]    out_mix_out,
  // configuration writes
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [rgm_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [15:0]                            cfg_data
);
  import rgm_pkg::*;

  `include "ramped_gain_mixer_dc_block_macros.svh"

  // Configuration registers.
  logic [15:0] ramp_step_r;
  logic [15:0] pole_coef_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ramp_step_r <= RAMP_STEP_RST;
      pole_coef_r <= POLE_COEF_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_RAMP_STEP: ramp_step_r <= cfg_data;
        REG_POLE_COEF: pole_coef_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Pipeline handshake. Words without frame_end retire in the sum stage.
  logic s1_v_r, s2_v_r, s3_v_r, out_v_r;
  logic s1_ready, s2_ready, s3_ready, out_ready;
  logic s1_fire, s2_fire, s3_fire;

  rgm_word_t                  s1_word_r;
  logic signed [PROD_W-1:0]   prod;
  logic                       hit;
  logic signed [PROD_W-1:0]   s2_prod_r;
  logic                       s2_hit_r;
  logic                       s2_fe_r;

  always_comb begin
    out_ready = !out_v_r || !out_stall;
    s3_ready  = !s3_v_r || out_ready;
    s3_fire   = s3_v_r && out_ready;
    s2_fire   = s2_v_r && (!s2_fe_r || s3_ready);
    s2_ready  = !s2_v_r || s2_fire;
    s1_fire   = s1_v_r && s2_ready;
    s1_ready  = !s1_v_r || s2_ready;
    in_stall  = !s1_ready;
  end

  // Stage 1: input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (s1_ready) begin
      s1_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && in_valid) begin
      s1_word_r.slot_index   <= in_slot_index;
      s1_word_r.slot_active  <= in_slot_active;
      s1_word_r.slot_muted   <= in_slot_muted;
      s1_word_r.target_level <= in_target_level;
      s1_word_r.tap_sample   <= in_tap_sample;
      s1_word_r.frame_end    <= in_frame_end;
    end
  end

  // Gain ramp and sample scaling; gains update as the word leaves stage 1.
  rgm_gain_ramp #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_gain_ramp (
    .clk       (clk),
    .rst_n     (rst_n),
    .upd_en    (s1_fire),
    .word      (s1_word_r),
    .ramp_step (ramp_step_r),
    .prod      (prod),
    .hit       (hit)
  );

  // Stage 2: scaled sample register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (s2_ready) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      s2_prod_r <= prod;
      s2_hit_r  <= hit;
      s2_fe_r   <= s1_word_r.frame_end;
    end
  end

  // Frame accumulation and the input half of the blocker.
  logic signed [SUM_W-1:0]  frame_sum_r;
  logic                     any_r;
  logic signed [SUM_W-1:0]  prev_sum_r;
  logic signed [PROD_W-1:0] prod_sh;
  logic signed [25:0]       addend;
  logic signed [SUM_W:0]    sum_ext;
  logic signed [SUM_W-1:0]  acc_nxt;
  logic                     any_nxt;
  logic signed [SUM_W:0]    diff_nxt;

  always_comb begin
    prod_sh  = s2_prod_r >>> 15;
    addend   = s2_hit_r ? prod_sh[25:0] : '0;
    sum_ext  = {frame_sum_r[SUM_W-1], frame_sum_r} + {{7{addend[25]}}, addend};
    acc_nxt  = sat32({sum_ext[SUM_W], sum_ext});
    any_nxt  = any_r || s2_hit_r;
    diff_nxt = {acc_nxt[SUM_W-1], acc_nxt} - {prev_sum_r[SUM_W-1], prev_sum_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_sum_r <= '0;
      any_r       <= 1'b0;
      prev_sum_r  <= '0;
    end else if (s2_fire) begin
      if (s2_fe_r) begin
        frame_sum_r <= '0;
        any_r       <= 1'b0;
        if (any_nxt) begin
          prev_sum_r <= acc_nxt;
        end
      end else begin
        frame_sum_r <= acc_nxt;
        any_r       <= any_nxt;
      end
    end
  end

  // Stage 3: one word per frame, holding x - x_prev.
  logic signed [SUM_W:0] s3_diff_r;
  logic                  s3_any_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (s3_ready) begin
      s3_v_r <= s2_v_r && s2_fe_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_fire && s2_fe_r) begin
      s3_diff_r <= diff_nxt;
      s3_any_r  <= any_nxt;
    end
  end

  // Blocker feedback: y = (x - x_prev) + floor(pole * y_prev / 2^16).
  logic signed [SUM_W-1:0]   blocker_out_r;
  logic [15:0]               pole_eff;
  logic signed [48:0]        pole_prod;
  logic signed [48:0]        pole_sh;
  logic signed [SUM_W:0]     pole_term;
  logic signed [SUM_W+1:0]   y_ext;
  logic signed [SUM_W-1:0]   y_nxt;
  logic signed [SAMPLE_W-1:0] mix_nxt;
  logic signed [SAMPLE_W-1:0] mix_out_r;

  always_comb begin
    pole_eff  = (pole_coef_r > POLE_MAX) ? POLE_MAX : pole_coef_r;
    pole_prod = $signed({1'b0, pole_eff}) * blocker_out_r;
    pole_sh   = pole_prod >>> 16;
    pole_term = pole_sh[SUM_W:0];
    y_ext     = {s3_diff_r[SUM_W], s3_diff_r} + {pole_term[SUM_W], pole_term};
    y_nxt     = sat32(y_ext);
    mix_nxt   = s3_any_r ? clamp_out(y_nxt) : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blocker_out_r <= '0;
    end else if (s3_fire && s3_any_r) begin
      blocker_out_r <= y_nxt;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (out_ready) begin
      out_v_r <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_fire) begin
      mix_out_r <= mix_nxt;
    end
  end

  assign out_valid   = out_v_r;
  assign out_mix_out = mix_out_r;

  // Checks.
  `RGM_ASSERT_NOW(a_mix_in_range, clk, rst_n, out_v_r,
    (SUM_W'(mix_out_r) <= OUT_LIMIT) && (SUM_W'(mix_out_r) >= -OUT_LIMIT),
    "mix output beyond 10 V")
  `RGM_ASSERT_NEXT(a_silent_zero, clk, rst_n, s3_fire && !s3_any_r,
    out_v_r && (mix_out_r == '0), "silent frame did not give zero")
  `RGM_ASSERT_NEXT(a_silent_hold, clk, rst_n, s3_fire && !s3_any_r,
    $stable(blocker_out_r), "silent frame changed the blocker state")
  `RGM_ASSERT_NEXT(a_frame_clear, clk, rst_n, s2_fire && s2_fe_r,
    (frame_sum_r == '0) && !any_r, "frame sum not cleared at frame end")

endmodule
